/* rtl/ald_pkg.sv */
// shared types and constants for the ambient light dimmer ramp unit
package ald_pkg;

    localparam int LUX_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int LEVEL_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int OUT_DUTY_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [LUX_W-1:0]   RST_BRIGHT_THR   = 16'd1000;
    localparam logic [LUX_W-1:0]   RST_MEDIUM_THR   = 16'd500;
    localparam logic [LUX_W-1:0]   RST_LOW_THR      = 16'd100;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_LOW    = 8'd64;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_MEDIUM = 8'd128;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_HIGH   = 8'd255;
    localparam logic [COUNT_W-1:0] RST_READS_NEEDED = 8'd3;
    localparam logic [LEVEL_W-1:0] RST_DIM_STEP     = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BRIGHT_THR   = 3'd0,
        REG_MEDIUM_THR   = 3'd1,
        REG_LOW_THR      = 3'd2,
        REG_LEVEL_LOW    = 3'd3,
        REG_LEVEL_MEDIUM = 3'd4,
        REG_LEVEL_HIGH   = 3'd5,
        REG_READS_NEEDED = 3'd6,
        REG_DIM_STEP     = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLASS_BRIGHT   = 2'd0,
        CLASS_HIGH_AMB = 2'd1,
        CLASS_MEDIUM   = 2'd2,
        CLASS_DARK     = 2'd3
    } ambient_class_t;

    typedef struct packed {
        logic [LUX_W-1:0]   bright_thr;
        logic [LUX_W-1:0]   medium_thr;
        logic [LUX_W-1:0]   low_thr;
        logic [LEVEL_W-1:0] level_low;
        logic [LEVEL_W-1:0] level_medium;
        logic [LEVEL_W-1:0] level_high;
        logic [COUNT_W-1:0] reads_needed;
        logic [LEVEL_W-1:0] dim_step;
    } cfg_t;

    typedef struct packed {
        logic committed;
        logic written;
    } ramp_flags_t;

endpackage

/* rtl/ald_cfg.sv */
// configuration register file
module ald_cfg
    import ald_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bright_thr   <= RST_BRIGHT_THR;
            cfg_reg.medium_thr   <= RST_MEDIUM_THR;
            cfg_reg.low_thr      <= RST_LOW_THR;
            cfg_reg.level_low    <= RST_LEVEL_LOW;
            cfg_reg.level_medium <= RST_LEVEL_MEDIUM;
            cfg_reg.level_high   <= RST_LEVEL_HIGH;
            cfg_reg.reads_needed <= RST_READS_NEEDED;
            cfg_reg.dim_step     <= RST_DIM_STEP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_BRIGHT_THR:   cfg_reg.bright_thr   <= cfg_data;
                REG_MEDIUM_THR:   cfg_reg.medium_thr   <= cfg_data;
                REG_LOW_THR:      cfg_reg.low_thr      <= cfg_data;
                REG_LEVEL_LOW:    cfg_reg.level_low    <= cfg_data[LEVEL_W-1:0];
                REG_LEVEL_MEDIUM: cfg_reg.level_medium <= cfg_data[LEVEL_W-1:0];
                REG_LEVEL_HIGH:   cfg_reg.level_high   <= cfg_data[LEVEL_W-1:0];
                REG_READS_NEEDED: cfg_reg.reads_needed <= cfg_data[COUNT_W-1:0];
                REG_DIM_STEP:     cfg_reg.dim_step     <= cfg_data[LEVEL_W-1:0];
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/ald_classify.sv */
// threshold classifier and required duty lookup
module ald_classify
    import ald_pkg::*;
#(
    parameter int DUTY_BITS = 8,
    parameter int OFF_LEVEL = 0
)
(
    input  logic [LUX_W-1:0]     lux,
    input  cfg_t                 cfg,
    output ambient_class_t       ambient_class,
    output logic [DUTY_BITS-1:0] required
);

    // first threshold test that holds wins
    always_comb
    begin
        if (lux >= cfg.bright_thr)
        begin
            ambient_class = CLASS_BRIGHT;
            required      = DUTY_BITS'(OFF_LEVEL);
        end
        else if (lux > cfg.medium_thr)
        begin
            ambient_class = CLASS_HIGH_AMB;
            required      = DUTY_BITS'(cfg.level_low);
        end
        else if (lux > cfg.low_thr)
        begin
            ambient_class = CLASS_MEDIUM;
            required      = DUTY_BITS'(cfg.level_medium);
        end
        else
        begin
            ambient_class = CLASS_DARK;
            required      = DUTY_BITS'(cfg.level_high);
        end
    end

endmodule

/* rtl/ald_ramp.sv */
// debounce counter, target commit and clamped duty ramp
module ald_ramp
    import ald_pkg::*;
#(
    parameter int DUTY_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  cfg_t                 cfg,
    input  logic [DUTY_BITS-1:0] required,
    output logic [DUTY_BITS-1:0] duty_next,
    output ramp_flags_t          flags
);

    localparam int SW = ((DUTY_BITS > LEVEL_W) ? DUTY_BITS : LEVEL_W) + 1;

    logic [DUTY_BITS-1:0] last_required_reg;
    logic                 last_valid_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [DUTY_BITS-1:0] target_reg;
    logic [DUTY_BITS-1:0] cur_reg;

    logic                 match;
    logic [COUNT_W-1:0]   count_inc;
    logic [COUNT_W-1:0]   count_next;
    logic                 commit;
    logic [DUTY_BITS-1:0] target_next;
    logic [SW-1:0]        cur_ext;
    logic [SW-1:0]        tgt_ext;
    logic [SW-1:0]        step_ext;
    logic [SW-1:0]        sum;
    logic [SW-1:0]        diff;
    logic                 written;

    assign match     = last_valid_reg && (required == last_required_reg);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign count_next = match ? count_inc : COUNT_W'(1);
    assign commit    = match && (count_inc >= cfg.reads_needed);
    assign target_next = commit ? required : target_reg;

    assign cur_ext  = SW'(cur_reg);
    assign tgt_ext  = SW'(target_next);
    assign step_ext = SW'(cfg.dim_step);
    assign sum      = cur_ext + step_ext;
    assign diff     = cur_ext - tgt_ext;

    always_comb
    begin
        written   = 1'b0;
        duty_next = cur_reg;
        if (cur_ext < tgt_ext)
        begin
            written   = 1'b1;
            duty_next = (sum > tgt_ext) ? target_next : DUTY_BITS'(sum);
        end
        else if (cur_ext > tgt_ext)
        begin
            written   = 1'b1;
            duty_next = (diff < step_ext) ? target_next : DUTY_BITS'(cur_ext - step_ext);
        end
    end

    assign flags.committed = commit;
    assign flags.written   = written;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
            count_reg      <= '0;
            target_reg     <= '0;
            cur_reg        <= '0;
        end
        else if (advance)
        begin
            last_valid_reg <= 1'b1;
            count_reg      <= count_next;
            target_reg     <= target_next;
            cur_reg        <= duty_next;
        end
    end

    // holds no meaning until the first reading
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            last_required_reg <= required;
        end
    end

`ifndef SYNTHESIS
    a_commit_needs_history: assert property (@(posedge clk) disable iff (!rst_n)
        advance && commit |-> last_valid_reg)
        else $error("commit without a previous reading");

    a_commit_sets_target: assert property (@(posedge clk) disable iff (!rst_n)
        advance && commit |=> target_reg == last_required_reg)
        else $error("committed target differs from stored required duty");

    a_no_overshoot_up: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cur_ext < tgt_ext) |=> cur_reg <= target_reg)
        else $error("duty ramped past target going up");

    a_no_overshoot_down: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cur_ext > tgt_ext) |=> cur_reg >= target_reg)
        else $error("duty ramped past target going down");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> cur_reg == $past(cur_reg) && count_reg == $past(count_reg))
        else $error("ramp state moved without a transfer");
`endif

endmodule

/* rtl/ambient_light_dimmer_ramp_unit.sv */
// top level of the ambient light dimmer ramp unit
//
//  channel   signals                                       direction
//  -------   -------------------------------------------   ---------
//  input     in_valid, in_ready, lux                       in
//  output    out_valid, out_ready, duty, ambient_class,    out
//            committed, duty_written
//  config    cfg_write, cfg_index, cfg_data                in
//
//  one reading per cycle sustained while out_ready holds high; each reading passes
//  through the input register, then classify/debounce/ramp into the result register
//  reset loads the default thresholds and levels and clears count, target and duty
//  with out_ready low the result holds, one more reading is buffered in the input
//  register, then in_ready drops
module ambient_light_dimmer_ramp_unit
    import ald_pkg::*;
#(
    parameter int DUTY_BITS = 8,
    parameter int OFF_LEVEL = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [LUX_W-1:0]      lux,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DUTY_W-1:0] duty,
    output logic [1:0]            ambient_class,
    output logic                  committed,
    output logic                  duty_written,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic [LUX_W-1:0]      lux_reg;
    logic                  out_valid_reg;
    logic [OUT_DUTY_W-1:0] duty_reg;
    ambient_class_t        class_reg;
    logic                  committed_reg;
    logic                  written_reg;
    logic                  advance;
    ambient_class_t        cls;
    logic [DUTY_BITS-1:0]  required;
    logic [DUTY_BITS-1:0]  duty_next;
    ramp_flags_t           flags;

    ald_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ald_classify #(
        .DUTY_BITS (DUTY_BITS),
        .OFF_LEVEL (OFF_LEVEL)
    ) u_classify (
        .lux           (lux_reg),
        .cfg           (cfg),
        .ambient_class (cls),
        .required      (required)
    );

    ald_ramp #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ramp (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cfg       (cfg),
        .required  (required),
        .duty_next (duty_next),
        .flags     (flags)
    );

    // buffered reading moves on when the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            lux_reg <= lux;
        end
        if (advance)
        begin
            duty_reg      <= OUT_DUTY_W'(duty_next);
            class_reg     <= cls;
            committed_reg <= flags.committed;
            written_reg   <= flags.written;
        end
    end

    assign out_valid     = out_valid_reg;
    assign duty          = duty_reg;
    assign ambient_class = class_reg;
    assign committed     = committed_reg;
    assign duty_written  = written_reg;

endmodule

/* sim/ambient_light_dimmer_ramp_unit_tb.sv */
// testbench for the ambient light dimmer ramp unit: directed and random readings, scoreboard
`timescale 1ns / 1ps

module ambient_light_dimmer_ramp_unit_tb;
    import ald_pkg::*;

    localparam int DUTY_BITS   = 8;
    localparam int OFF_LEVEL   = 0;
    localparam int CLK_HALF_NS = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_READINGS = 350;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_LIMIT = 10;

    localparam logic [LEVEL_W-1:0] OFF_DUTY = OFF_LEVEL[LEVEL_W-1:0];

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_mode_t;

    typedef struct packed {
        logic [OUT_DUTY_W-1:0] duty;
        ambient_class_t        cls;
        logic                  committed;
        logic                  written;
    } dimmer_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [LUX_W-1:0]      lux;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    logic [OUT_DUTY_W-1:0] duty;
    logic [1:0]            ambient_class;
    logic                  committed;
    logic                  duty_written;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor copy of the block's settings and state
    cfg_t               shadow_cfg;
    logic [LEVEL_W-1:0] seen_required;
    logic               have_reading;
    logic [COUNT_W-1:0] match_count;
    logic [LEVEL_W-1:0] target_level;
    logic [LEVEL_W-1:0] drive_level;

    dimmer_result_t pending_results[$];
    int             mismatch_count;
    rx_mode_t       rx_mode;
    int             rx_tick;
    bit             gaps_on;
    int             burst_left;

    ambient_light_dimmer_ramp_unit #(
        .DUTY_BITS (DUTY_BITS),
        .OFF_LEVEL (OFF_LEVEL)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .lux           (lux),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .duty          (duty),
        .ambient_class (ambient_class),
        .committed     (committed),
        .duty_written  (duty_written),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF_NS clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // classify, debounce and ramp one reading, updating the predictor state
    function automatic dimmer_result_t step_dimmer(input logic [LUX_W-1:0] reading);
        dimmer_result_t     res;
        logic [LEVEL_W-1:0] need;
        int                 next_level;
        res = '0;
        if (reading >= shadow_cfg.bright_thr)
        begin
            res.cls = CLASS_BRIGHT;
            need = OFF_DUTY;
        end
        else if (reading > shadow_cfg.medium_thr)
        begin
            res.cls = CLASS_HIGH_AMB;
            need = shadow_cfg.level_low;
        end
        else if (reading > shadow_cfg.low_thr)
        begin
            res.cls = CLASS_MEDIUM;
            need = shadow_cfg.level_medium;
        end
        else
        begin
            res.cls = CLASS_DARK;
            need = shadow_cfg.level_high;
        end

        // duties are compared, not classes
        if (!have_reading || need != seen_required)
        begin
            seen_required = need;
            have_reading = 1'b1;
            match_count = COUNT_W'(1);
        end
        else
        begin
            if (match_count != COUNT_MAX)
                match_count = match_count + 1'b1;
            if (match_count >= shadow_cfg.reads_needed)
            begin
                target_level = need;
                res.committed = 1'b1;
            end
        end

        if (drive_level < target_level)
        begin
            next_level = int'(drive_level) + int'(shadow_cfg.dim_step);
            drive_level = (next_level > int'(target_level)) ? target_level
                                                            : next_level[LEVEL_W-1:0];
            res.written = 1'b1;
        end
        else if (drive_level > target_level)
        begin
            if (int'(drive_level) - int'(target_level) < int'(shadow_cfg.dim_step))
                drive_level = target_level;
            else
                drive_level = drive_level - shadow_cfg.dim_step;
            res.written = 1'b1;
        end
        res.duty = drive_level;
        return res;
    endfunction

    // reading near a threshold, at a field extreme, or anywhere
    function automatic logic [LUX_W-1:0] pick_lux();
        logic [LUX_W-1:0] thr;
        case ($urandom_range(0, 3))
            0: thr = shadow_cfg.bright_thr;
            1: thr = shadow_cfg.medium_thr;
            2: thr = shadow_cfg.low_thr;
            default: return LUX_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 4))
            0: return thr - 1'b1;
            1: return thr;
            2: return thr + 1'b1;
            3: return $urandom_range(0, 1) ? '0 : '1;
            default: return thr + LUX_W'($urandom_range(0, 200)) - LUX_W'(100);
        endcase
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input int value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        case (idx)
            REG_BRIGHT_THR:   shadow_cfg.bright_thr   = value[LUX_W-1:0];
            REG_MEDIUM_THR:   shadow_cfg.medium_thr   = value[LUX_W-1:0];
            REG_LOW_THR:      shadow_cfg.low_thr      = value[LUX_W-1:0];
            REG_LEVEL_LOW:    shadow_cfg.level_low    = value[LEVEL_W-1:0];
            REG_LEVEL_MEDIUM: shadow_cfg.level_medium = value[LEVEL_W-1:0];
            REG_LEVEL_HIGH:   shadow_cfg.level_high   = value[LEVEL_W-1:0];
            REG_READS_NEEDED: shadow_cfg.reads_needed = value[COUNT_W-1:0];
            REG_DIM_STEP:     shadow_cfg.dim_step     = value[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_reading(input logic [LUX_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        lux      <= value;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(step_dimmer(value));
    endtask

    task automatic send_run(input logic [LUX_W-1:0] value, input int count);
        repeat (count) send_reading(value);
    endtask

    // stop sending and let every outstanding result arrive
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver stall patterns
    always @(negedge clk)
    begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_ALWAYS:   out_ready <= 1'b1;
            RX_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: out_ready <= ((rx_tick % 7) >= 3);
            RX_BURSTY:   out_ready <= ((rx_tick % 32) < 20);
            default:     out_ready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        dimmer_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("unexpected result: duty %0d class %0d committed %0b written %0b",
                             duty, ambient_class, committed, duty_written);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (duty !== want.duty || ambient_class !== want.cls ||
                    committed !== want.committed || duty_written !== want.written)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                    begin
                        $display("mismatch at %0t: expected duty %0d class %0d committed %0b %s",
                                 $realtime, want.duty, want.cls, want.committed, "");
                        $display("  expected written %0b, got duty %0d class %0d %s",
                                 want.written, duty, ambient_class, "");
                        $display("  got committed %0b written %0b", committed, duty_written);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_default_levels();
        rx_mode = RX_ALWAYS;
        gaps_on = 1'b0;
        send_reading(16'd0);
        send_reading(16'hFFFF);
        send_reading(16'd100);
        send_reading(16'd101);
        send_reading(16'd500);
        send_reading(16'd501);
        send_reading(16'd999);
        send_reading(16'd1000);
        send_run(16'd0, 4);
        send_run(16'hFFFF, 3);
        rx_mode = RX_PERIODIC;
        send_run(16'd700, 3);
        send_run(16'd300, 2);
        settle();
    endtask

    task automatic test_threshold_order();
        rx_mode = RX_RANDOM;
        gaps_on = 1'b1;
        // everything reads as bright
        write_reg(REG_BRIGHT_THR, 0);
        send_reading(16'd0);
        send_reading(16'hFFFF);
        settle();
        write_reg(REG_BRIGHT_THR, 65535);
        write_reg(REG_MEDIUM_THR, 65535);
        write_reg(REG_LOW_THR, 0);
        send_run(16'd0, 2);
        send_run(16'd1, 2);
        send_run(16'hFFFE, 2);
        send_reading(16'hFFFF);
        settle();
        // thresholds out of order: first test that holds wins
        write_reg(REG_BRIGHT_THR, 100);
        write_reg(REG_MEDIUM_THR, 500);
        write_reg(REG_LOW_THR, 1000);
        send_run(16'd600, 2);
        send_run(16'd50, 2);
        settle();
        write_reg(REG_BRIGHT_THR, 300);
        write_reg(REG_MEDIUM_THR, 50);
        write_reg(REG_LOW_THR, 200);
        send_run(16'd100, 2);
        send_reading(16'd40);
        settle();
    endtask

    task automatic test_shared_levels();
        rx_mode = RX_BURSTY;
        write_reg(REG_BRIGHT_THR, 1000);
        write_reg(REG_MEDIUM_THR, 500);
        write_reg(REG_LOW_THR, 100);
        write_reg(REG_LEVEL_LOW, 90);
        write_reg(REG_LEVEL_MEDIUM, 90);
        write_reg(REG_LEVEL_HIGH, 0);
        write_reg(REG_READS_NEEDED, 3);
        // high ambient and medium share a duty, so they count together
        send_reading(16'd600);
        send_reading(16'd200);
        send_reading(16'd700);
        send_reading(16'd300);
        // dark now maps to the off duty, same as bright
        send_reading(16'd2000);
        send_reading(16'd10);
        send_reading(16'd5000);
        send_run(16'd0, 3);
        settle();
    endtask

    task automatic test_commit_counts();
        int needed;
        rx_mode = RX_RANDOM;
        write_reg(REG_LEVEL_LOW, 0);
        write_reg(REG_LEVEL_MEDIUM, 255);
        write_reg(REG_LEVEL_HIGH, 200);
        write_reg(REG_DIM_STEP, 7);
        for (needed = 0; needed <= 2; needed++)
        begin
            write_reg(REG_READS_NEEDED, needed);
            send_run(16'd300, 3);
            send_run(16'd0, 2);
            settle();
        end
        // count saturates at its commit point and the run goes well past it
        write_reg(REG_READS_NEEDED, 255);
        write_reg(REG_DIM_STEP, 1);
        send_run(16'd300, 260);
        send_reading(16'd20);
        send_run(16'd20, 3);
        settle();
    endtask

    task automatic test_ramp_steps();
        rx_mode = RX_PERIODIC;
        write_reg(REG_READS_NEEDED, 2);
        write_reg(REG_LEVEL_HIGH, 255);
        write_reg(REG_DIM_STEP, 255);
        send_run(16'd0, 4);
        send_run(16'hFFFF, 4);
        settle();
        write_reg(REG_DIM_STEP, 1);
        send_run(16'd0, 6);
        send_run(16'hFFFF, 4);
        settle();
        // zero step: duty stays put but writes keep being issued
        write_reg(REG_DIM_STEP, 0);
        send_run(16'd0, 5);
        settle();
    endtask

    task automatic test_random_traffic();
        int               sent;
        int               len;
        int               setting;
        int               t0;
        int               t1;
        int               t2;
        int               tmp;
        logic [LUX_W-1:0] base;
        sent = 0;
        for (setting = 0; setting < 7; setting++)
        begin
            settle();
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) == 0)
            begin
                t0 = $urandom_range(0, 65535);
                t1 = $urandom_range(0, 65535);
                t2 = $urandom_range(0, 65535);
            end
            else
            begin
                t0 = $urandom_range(0, 2000);
                t1 = $urandom_range(0, 2000);
                t2 = $urandom_range(0, 2000);
                if (t0 < t1) begin tmp = t0; t0 = t1; t1 = tmp; end
                if (t1 < t2) begin tmp = t1; t1 = t2; t2 = tmp; end
                if (t0 < t1) begin tmp = t0; t0 = t1; t1 = tmp; end
            end
            write_reg(REG_BRIGHT_THR, t0);
            write_reg(REG_MEDIUM_THR, t1);
            write_reg(REG_LOW_THR, t2);
            write_reg(REG_LEVEL_LOW, $urandom_range(0, 255));
            write_reg(REG_LEVEL_MEDIUM, $urandom_range(0, 255));
            write_reg(REG_LEVEL_HIGH, $urandom_range(0, 255));
            write_reg(REG_READS_NEEDED, ($urandom_range(0, 7) == 0) ? 255
                                                                    : $urandom_range(1, 6));
            write_reg(REG_DIM_STEP, $urandom_range(0, 1) ? $urandom_range(1, 255)
                                                         : $urandom_range(1, 20));
            while (sent < (setting + 1) * RANDOM_READINGS / 7)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // steady stretch with the odd stray reading
                    base = pick_lux();
                    len = $urandom_range(1, 12);
                    repeat (len)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send_reading(LUX_W'($urandom_range(0, 65535)));
                        else
                            send_reading(base);
                        sent++;
                    end
                end
                else
                begin
                    send_reading(LUX_W'($urandom_range(0, 65535)));
                    sent++;
                end
                if ($urandom_range(0, 39) == 0)
                    settle();
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        lux        = '0;
        cfg_write  = 1'b0;
        cfg_index  = REG_BRIGHT_THR;
        cfg_data   = '0;
        rx_mode    = RX_ALWAYS;
        rx_tick    = 0;
        gaps_on    = 1'b0;
        burst_left = 0;
        mismatch_count = 0;

        shadow_cfg.bright_thr   = RST_BRIGHT_THR;
        shadow_cfg.medium_thr   = RST_MEDIUM_THR;
        shadow_cfg.low_thr      = RST_LOW_THR;
        shadow_cfg.level_low    = RST_LEVEL_LOW;
        shadow_cfg.level_medium = RST_LEVEL_MEDIUM;
        shadow_cfg.level_high   = RST_LEVEL_HIGH;
        shadow_cfg.reads_needed = RST_READS_NEEDED;
        shadow_cfg.dim_step     = RST_DIM_STEP;
        seen_required = '0;
        have_reading  = 1'b0;
        match_count   = '0;
        target_level  = '0;
        drive_level   = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_levels();
        test_threshold_order();
        test_shared_levels();
        test_commit_counts();
        test_ramp_steps();
        test_random_traffic();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
